// File: src/assert_macros.svh
// Assertion macros used by the checker file of the touch frame decoder.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TFD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfd_checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfd_checker: next-cycle check failed");

`endif

// File: src/tfd_pkg.sv
// Types and constants of the touch frame decoder.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package tfd_pkg;

  // Frame layout.
  localparam logic [4:0] POS_HDR0       = 5'd0;
  localparam logic [4:0] POS_HDR1       = 5'd1;
  localparam logic [4:0] POS_LEN        = 5'd2;
  localparam logic [4:0] POS_CONTACT    = 5'd3;
  localparam logic [4:0] POS_FIRST_SLOT = 5'd5;
  localparam logic [4:0] POS_LAST_SLOT  = 5'd24;
  localparam logic [4:0] POS_LAST       = 5'd25;
  localparam logic [4:0] POS_DONE       = 5'd26;
  localparam logic [2:0] MAX_SLOTS      = 3'd5;

  // Byte phases inside one slot's four bytes.
  localparam logic [1:0] PH_X_HI = 2'd0;
  localparam logic [1:0] PH_X_LO = 2'd1;
  localparam logic [1:0] PH_Y_HI = 2'd2;
  localparam logic [1:0] PH_Y_LO = 2'd3;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] LEN_MASK  = 8'h3F;
  localparam logic [7:0] LEN_VALUE = 8'd26;

  // x = rx * 800 / 1792 = ((rx * 25) >> 3) / 7, and x < 800 exactly when rx < 1792.
  localparam logic [11:0] RX_LIMIT = 12'd1792;
  localparam logic [15:0] X_RECIP  = 16'd9363;

  localparam logic [10:0] Y_LIMIT     = 11'd480;
  localparam logic [10:0] Y_LOW_SKIP  = 11'd5;
  localparam logic [10:0] Y_HIGH_SKIP = 11'd475;
  localparam logic [10:0] Y_LOW_BAND  = 11'd15;
  localparam logic [10:0] Y_HIGH_BAND = 11'd460;
  localparam logic [10:0] Y_NUDGE     = 11'd5;

  localparam logic [9:0] X_OUT_LIMIT = 10'd800;
  localparam logic [8:0] Y_OUT_LIMIT = 9'd480;
  localparam logic [3:0] WIDTH_TOUCH = 4'd12;
  localparam logic [3:0] WIDTH_NONE  = 4'd0;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_END     = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STR_IDLE     = 2'd0,
    STR_RELEASED = 2'd1,
    STR_CONTACT  = 2'd2
  } strength_t;

  typedef enum logic [1:0] {
    BK_SLOT    = 2'd0,
    BK_RELEASE = 2'd1,
    BK_END     = 2'd2
  } back_state_t;

  typedef struct packed {
    logic ok;
    logic contact;
  } frame_hdr_t;

  typedef struct packed {
    logic       x_ok;
    logic [9:0] x;
    logic       y_ok;
    logic       skip;
    logic [8:0] y_adj;
  } slot_rec_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] slot;
    logic [9:0] x_pos;
    logic [8:0] y_pos;
    logic [3:0] width;
    logic       pressed;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// File: src/tfd_front.sv
// Front end: accepts frame bytes, checks the header and XOR sum, and decodes
// each slot's coordinates as its bytes arrive. Depends on tfd_pkg.
`default_nettype none

module tfd_front #(
  parameter int SLOT_COUNT = 5,
  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [7:0]                             frame_byte,
  input  wire logic                                   frame_start,
  input  wire logic                                   q_full,
  output logic                                        push,
  output tfd_pkg::frame_hdr_t                         push_hdr,
  output tfd_pkg::slot_rec_t [SLOT_COUNT-1:0]         push_slots
);

  logic [4:0]  pos;
  logic [4:0]  pos_eff;
  logic [7:0]  xor_acc;
  logic [7:0]  xor_next;
  logic        hdr_ok;
  logic        contact;
  logic [11:0] rx;
  logic [3:0]  ry_hi;
  logic        take;
  logic [4:0]  off;
  logic [2:0]  sidx;
  logic [1:0]  phase;
  logic        in_slot;

  logic [16:0] rx25;
  logic [13:0] x_div8;
  logic [29:0] x_prod;
  logic        x_ok_c;
  logic [11:0] ry;
  logic [15:0] ry15;
  logic [10:0] y_c;
  logic [10:0] y_adj_c;

  tfd_pkg::slot_rec_t [SLOT_COUNT-1:0] slots;

  assign in_stall = q_full;

  // A start byte always restarts collection at byte 0.
  assign pos_eff  = frame_start ? tfd_pkg::POS_HDR0 : pos;
  assign xor_next = (frame_start ? 8'd0 : xor_acc) ^ frame_byte;
  assign take     = in_valid && !q_full && (pos_eff < tfd_pkg::POS_DONE);

  assign off     = pos_eff - tfd_pkg::POS_FIRST_SLOT;
  assign sidx    = off[4:2];
  assign phase   = off[1:0];
  assign in_slot = (pos_eff >= tfd_pkg::POS_FIRST_SLOT) && (pos_eff <= tfd_pkg::POS_LAST_SLOT)
                   && (sidx < 3'(SLOT_COUNT));

  // x from the stored raw x: multiply by 25, drop three bits, divide by seven.
  assign rx25   = 17'({rx, 4'b0000}) + 17'({rx, 3'b000}) + 17'(rx);
  assign x_div8 = rx25[16:3];
  assign x_prod = 30'(x_div8) * 30'(tfd_pkg::X_RECIP);
  assign x_ok_c = rx < tfd_pkg::RX_LIMIT;

  // y = ry * 15 / 32, then the edge bands are nudged outwards, towards the nearer edge.
  assign ry   = {ry_hi, frame_byte};
  assign ry15 = {ry, 4'b0000} - 16'(ry);
  assign y_c  = ry15[15:5];

  always_comb begin
    if (y_c <= tfd_pkg::Y_LOW_BAND) begin
      y_adj_c = y_c - tfd_pkg::Y_NUDGE;
    end else if (y_c >= tfd_pkg::Y_HIGH_BAND) begin
      y_adj_c = y_c + tfd_pkg::Y_NUDGE;
    end else begin
      y_adj_c = y_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= tfd_pkg::POS_HDR0;
      xor_acc <= 8'd0;
    end else if (take) begin
      pos     <= pos_eff + 5'd1;
      xor_acc <= xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (pos_eff)
        tfd_pkg::POS_HDR0:    hdr_ok  <= (frame_byte == tfd_pkg::HDR_BYTE);
        tfd_pkg::POS_HDR1:    hdr_ok  <= hdr_ok && (frame_byte == tfd_pkg::HDR_BYTE);
        tfd_pkg::POS_LEN:     hdr_ok  <= hdr_ok
                                         && ((frame_byte & tfd_pkg::LEN_MASK) == tfd_pkg::LEN_VALUE);
        tfd_pkg::POS_CONTACT: contact <= (frame_byte != 8'd0);
        default: ;
      endcase
      if (in_slot) begin
        case (phase)
          tfd_pkg::PH_X_HI: rx[11:8] <= frame_byte[3:0];
          tfd_pkg::PH_X_LO: rx[7:0]  <= frame_byte;
          tfd_pkg::PH_Y_HI: begin
            ry_hi                         <= frame_byte[3:0];
            slots[sidx[SIDX_W-1:0]].x_ok  <= x_ok_c;
            slots[sidx[SIDX_W-1:0]].x     <= x_prod[25:16];
          end
          default: begin
            slots[sidx[SIDX_W-1:0]].y_ok  <= (y_c < tfd_pkg::Y_LIMIT);
            slots[sidx[SIDX_W-1:0]].skip  <= (y_c <= tfd_pkg::Y_LOW_SKIP)
                                             || (y_c >= tfd_pkg::Y_HIGH_SKIP);
            slots[sidx[SIDX_W-1:0]].y_adj <= y_adj_c[8:0];
          end
        endcase
      end
    end
  end

  assign push             = take && (pos_eff == tfd_pkg::POS_LAST);
  assign push_hdr.ok      = hdr_ok && (xor_next == 8'd0);
  assign push_hdr.contact = contact;
  assign push_slots       = slots;

endmodule

`default_nettype wire

// File: src/tfd_queue.sv
// Two-entry queue of decoded frames between the front and back ends.
// Depends on tfd_pkg.
`default_nettype none

module tfd_queue #(
  parameter int SLOT_COUNT = 5
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  input  wire tfd_pkg::frame_hdr_t                    push_hdr,
  input  wire tfd_pkg::slot_rec_t [SLOT_COUNT-1:0]    push_slots,
  output logic                                        full,
  output logic                                        head_valid,
  output tfd_pkg::frame_hdr_t                         head_hdr,
  output tfd_pkg::slot_rec_t [SLOT_COUNT-1:0]         head_slots,
  input  wire logic                                   pop
);

  tfd_pkg::frame_hdr_t                 hdr_mem   [2];
  tfd_pkg::slot_rec_t [SLOT_COUNT-1:0] slots_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_hdr   = hdr_mem[rd_ptr];
  assign head_slots = slots_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hdr_mem[wr_ptr]   <= push_hdr;
      slots_mem[wr_ptr] <= push_slots;
    end
  end

endmodule

`default_nettype wire

// File: src/tfd_back.sv
// Back end: walks the slots of each decoded frame, keeps slot strength and
// drives the result register. Depends on tfd_pkg.
`default_nettype none

module tfd_back #(
  parameter int SLOT_COUNT = 5,
  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   q_valid,
  input  wire tfd_pkg::frame_hdr_t                    q_hdr,
  input  wire tfd_pkg::slot_rec_t [SLOT_COUNT-1:0]    q_slots,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output tfd_pkg::result_t                            out_res
);

  tfd_pkg::back_state_t state;
  tfd_pkg::back_state_t state_next;
  logic [SIDX_W-1:0]    idx;
  logic [SIDX_W-1:0]    idx_next;
  tfd_pkg::strength_t   strength [SLOT_COUNT];

  logic               adv;
  logic               go;
  logic               last_slot;
  tfd_pkg::slot_rec_t rec;
  tfd_pkg::strength_t eff;
  logic               emit;
  tfd_pkg::result_t   res;
  logic               str_we;
  tfd_pkg::strength_t str_wd;

  assign adv       = !out_valid || !out_stall;
  assign go        = q_valid && adv;
  assign last_slot = (idx == SIDX_W'(SLOT_COUNT - 1));
  assign rec       = q_slots[idx];

  // A slot inside the panel takes its strength from this frame; otherwise it keeps the old one.
  always_comb begin
    if (rec.x_ok && rec.y_ok) begin
      eff = q_hdr.contact ? tfd_pkg::STR_CONTACT : tfd_pkg::STR_RELEASED;
    end else begin
      eff = strength[idx];
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    if (go) begin
      unique case (state)
        tfd_pkg::BK_SLOT: begin
          if (!q_hdr.ok) begin
            idx_next = '0;
          end else if (!rec.skip && rec.x_ok && (eff == tfd_pkg::STR_RELEASED)) begin
            state_next = tfd_pkg::BK_RELEASE;
          end else if (last_slot) begin
            state_next = tfd_pkg::BK_END;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        tfd_pkg::BK_RELEASE: begin
          if (last_slot) begin
            state_next = tfd_pkg::BK_END;
          end else begin
            state_next = tfd_pkg::BK_SLOT;
            idx_next   = idx + 1'b1;
          end
        end
        tfd_pkg::BK_END: begin
          state_next = tfd_pkg::BK_SLOT;
          idx_next   = '0;
        end
        default: begin
          state_next = tfd_pkg::BK_SLOT;
          idx_next   = '0;
        end
      endcase
    end
  end

  always_comb begin
    emit        = 1'b0;
    q_pop       = 1'b0;
    str_we      = 1'b0;
    str_wd      = eff;
    res         = '0;
    res.kind    = tfd_pkg::KIND_POINT;
    res.slot    = 3'(idx);
    if (go) begin
      unique case (state)
        tfd_pkg::BK_SLOT: begin
          if (!q_hdr.ok) begin
            emit     = 1'b1;
            q_pop    = 1'b1;
            res.kind = tfd_pkg::KIND_REJECT;
            res.slot = 3'd0;
            res.last = 1'b1;
          end else begin
            str_we = 1'b1;
            if (!rec.skip && (eff != tfd_pkg::STR_IDLE)) begin
              if (rec.x_ok) begin
                emit        = 1'b1;
                res.x_pos   = rec.x;
                res.y_pos   = rec.y_adj;
                res.width   = q_hdr.contact ? tfd_pkg::WIDTH_TOUCH : tfd_pkg::WIDTH_NONE;
                res.pressed = (eff == tfd_pkg::STR_CONTACT);
              end else if (eff == tfd_pkg::STR_RELEASED) begin
                emit     = 1'b1;
                res.kind = tfd_pkg::KIND_RELEASE;
                str_wd   = tfd_pkg::STR_IDLE;
              end
            end
          end
        end
        tfd_pkg::BK_RELEASE: begin
          emit     = 1'b1;
          res.kind = tfd_pkg::KIND_RELEASE;
          str_we   = 1'b1;
          str_wd   = tfd_pkg::STR_IDLE;
        end
        tfd_pkg::BK_END: begin
          emit     = 1'b1;
          q_pop    = 1'b1;
          res.kind = tfd_pkg::KIND_END;
          res.slot = 3'd0;
          res.last = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tfd_pkg::BK_SLOT;
      idx       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        strength[i] <= tfd_pkg::STR_IDLE;
      end
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (str_we) begin
        strength[idx] <= str_wd;
      end
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: src/touch_frame_decoder_unit.sv
// Touch frame decoder, top level: front end, frame queue and back end.
// Depends on tfd_pkg, tfd_front, tfd_queue and tfd_back.
//
// Takes one 26-byte touch frame a byte at a time, up to one byte per clock.
// Each slot's coordinates are decoded while its bytes arrive, so a complete
// frame enters a two-entry queue in the cycle its last byte is accepted.
// The back end then walks the slots in turn, giving point reports and
// release notices, and ends each frame with a frame-end result; a rejected
// frame gives a single reject result. Results leave through a single
// output register. The input is stalled only while both queue entries hold
// frames not yet reported.
`default_nettype none

module touch_frame_decoder_unit #(
  parameter int SLOT_COUNT = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] frame_byte,
  input  wire logic       frame_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [2:0]      slot,
  output logic [9:0]      x_pos,
  output logic [8:0]      y_pos,
  output logic [3:0]      contact_width,
  output logic            pressed,
  output logic            last
);

  logic                                q_full;
  logic                                push;
  tfd_pkg::frame_hdr_t                 push_hdr;
  tfd_pkg::slot_rec_t [SLOT_COUNT-1:0] push_slots;
  logic                                q_valid;
  tfd_pkg::frame_hdr_t                 q_hdr;
  tfd_pkg::slot_rec_t [SLOT_COUNT-1:0] q_slots;
  logic                                q_pop;
  tfd_pkg::result_t                    out_res;

  tfd_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_byte (frame_byte),
    .frame_start(frame_start),
    .q_full     (q_full),
    .push       (push),
    .push_hdr   (push_hdr),
    .push_slots (push_slots)
  );

  tfd_queue #(.SLOT_COUNT(SLOT_COUNT)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_hdr  (push_hdr),
    .push_slots(push_slots),
    .full      (q_full),
    .head_valid(q_valid),
    .head_hdr  (q_hdr),
    .head_slots(q_slots),
    .pop       (q_pop)
  );

  tfd_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_hdr    (q_hdr),
    .q_slots  (q_slots),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign kind          = out_res.kind;
  assign slot          = out_res.slot;
  assign x_pos         = out_res.x_pos;
  assign y_pos         = out_res.y_pos;
  assign contact_width = out_res.width;
  assign pressed       = out_res.pressed;
  assign last          = out_res.last;

endmodule

`default_nettype wire

// File: src/tfd_checker.sv
// Port-level checker for the touch frame decoder and its bind statement.
// Depends on tfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tfd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic [2:0] slot,
  input wire logic [9:0] x_pos,
  input wire logic [8:0] y_pos,
  input wire logic [3:0] contact_width,
  input wire logic       pressed,
  input wire logic       last
);

  // A result held back by the receiver keeps every field.
  `TFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind) && $stable(slot) && $stable(x_pos) && $stable(y_pos) && $stable(contact_width) && $stable(pressed) && $stable(last))

  // Only frame-end and reject results close the transactions caused by one frame.
  `TFD_ASSERT_IMPL(a_last_kind, clk, rst, out_valid, last == ((kind == tfd_pkg::KIND_END) || (kind == tfd_pkg::KIND_REJECT)))

  // Results other than point reports carry no coordinates, width or press.
  `TFD_ASSERT_IMPL(a_non_point_zero, clk, rst, out_valid && (kind != tfd_pkg::KIND_POINT), (x_pos == 10'd0) && (y_pos == 9'd0) && (contact_width == tfd_pkg::WIDTH_NONE) && !pressed)

  // Point reports stay on the panel and name a real slot.
  `TFD_ASSERT_IMPL(a_point_range, clk, rst, out_valid && (kind == tfd_pkg::KIND_POINT), (x_pos < tfd_pkg::X_OUT_LIMIT) && (y_pos < tfd_pkg::Y_OUT_LIMIT) && (slot < tfd_pkg::MAX_SLOTS))

endmodule

bind touch_frame_decoder_unit tfd_checker u_tfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .slot         (slot),
  .x_pos        (x_pos),
  .y_pos        (y_pos),
  .contact_width(contact_width),
  .pressed      (pressed),
  .last         (last)
);

`default_nettype wire
